FILE: rtl/sbc_pkg.sv
// ----------------------------------------------------------------------------
// sbc_pkg
// Shared types, constants, bitsliced s-box and linear transform functions for the cipher.
// ----------------------------------------------------------------------------
package sbc_pkg;

  localparam int unsigned NumRounds   = 32;
  localparam int unsigned NumKeyWords = 132;
  localparam int unsigned NumGroups   = 33;
  localparam logic [31:0] PhiConst    = 32'h9e3779b9;

  localparam logic [2:0] CfgKeyPart0  = 3'd0;
  localparam logic [2:0] CfgKeyPart1  = 3'd1;
  localparam logic [2:0] CfgKeyPart2  = 3'd2;
  localparam logic [2:0] CfgKeyPart3  = 3'd3;
  localparam logic [2:0] CfgKeyLength = 3'd4;

  localparam logic ActEncrypt = 1'b0;
  localparam logic ActDecrypt = 1'b1;

  typedef logic [31:0] word_t;
  typedef word_t [3:0] quad_t;
  typedef logic [3:0] nib_t;

  localparam nib_t SboxTab [8][16] = '{
    '{4'd3, 4'd8, 4'd15, 4'd1, 4'd10, 4'd6, 4'd5, 4'd11,
      4'd14, 4'd13, 4'd4, 4'd2, 4'd7, 4'd0, 4'd9, 4'd12},
    '{4'd15, 4'd12, 4'd2, 4'd7, 4'd9, 4'd0, 4'd5, 4'd10,
      4'd1, 4'd11, 4'd14, 4'd8, 4'd6, 4'd13, 4'd3, 4'd4},
    '{4'd8, 4'd6, 4'd7, 4'd9, 4'd3, 4'd12, 4'd10, 4'd15,
      4'd13, 4'd1, 4'd14, 4'd4, 4'd0, 4'd11, 4'd5, 4'd2},
    '{4'd0, 4'd15, 4'd11, 4'd8, 4'd12, 4'd9, 4'd6, 4'd3,
      4'd13, 4'd1, 4'd2, 4'd4, 4'd10, 4'd7, 4'd5, 4'd14},
    '{4'd1, 4'd15, 4'd8, 4'd3, 4'd12, 4'd0, 4'd11, 4'd6,
      4'd2, 4'd5, 4'd4, 4'd10, 4'd9, 4'd14, 4'd7, 4'd13},
    '{4'd15, 4'd5, 4'd2, 4'd11, 4'd4, 4'd10, 4'd9, 4'd12,
      4'd0, 4'd3, 4'd14, 4'd8, 4'd13, 4'd6, 4'd7, 4'd1},
    '{4'd7, 4'd2, 4'd12, 4'd5, 4'd8, 4'd4, 4'd6, 4'd11,
      4'd14, 4'd9, 4'd1, 4'd15, 4'd13, 4'd3, 4'd10, 4'd0},
    '{4'd1, 4'd13, 4'd15, 4'd0, 4'd14, 4'd8, 4'd2, 4'd11,
      4'd7, 4'd4, 4'd12, 4'd10, 4'd9, 4'd3, 4'd5, 4'd6}
  };

  function automatic nib_t sbox_lookup(logic [2:0] box, logic inv, nib_t n);
    nib_t r;
    r = '0;
    if (!inv) begin
      r = SboxTab[box][n];
    end else begin
      for (int v = 0; v < 16; v++) begin
        if (SboxTab[box][v] == n) begin
          r = 4'(v);
        end
      end
    end
    return r;
  endfunction

  function automatic quad_t sbox_apply(logic [2:0] box, logic inv, quad_t x);
    quad_t y;
    nib_t  n;
    nib_t  o;
    for (int j = 0; j < 32; j++) begin
      n = {x[3][j], x[2][j], x[1][j], x[0][j]};
      o = sbox_lookup(box, inv, n);
      y[0][j] = o[0];
      y[1][j] = o[1];
      y[2][j] = o[2];
      y[3][j] = o[3];
    end
    return y;
  endfunction

  function automatic quad_t lin_fwd(quad_t xi);
    quad_t x;
    x = xi;
    x[0] = {x[0][18:0], x[0][31:19]};
    x[2] = {x[2][28:0], x[2][31:29]};
    x[1] = x[1] ^ x[0] ^ x[2];
    x[3] = x[3] ^ x[2] ^ (x[0] << 3);
    x[1] = {x[1][30:0], x[1][31]};
    x[3] = {x[3][24:0], x[3][31:25]};
    x[0] = x[0] ^ x[1] ^ x[3];
    x[2] = x[2] ^ x[3] ^ (x[1] << 7);
    x[0] = {x[0][26:0], x[0][31:27]};
    x[2] = {x[2][9:0], x[2][31:10]};
    return x;
  endfunction

  function automatic quad_t lin_inv(quad_t xi);
    quad_t x;
    x = xi;
    x[2] = {x[2][21:0], x[2][31:22]};
    x[0] = {x[0][4:0], x[0][31:5]};
    x[2] = x[2] ^ x[3] ^ (x[1] << 7);
    x[0] = x[0] ^ x[1] ^ x[3];
    x[3] = {x[3][6:0], x[3][31:7]};
    x[1] = {x[1][0], x[1][31:1]};
    x[3] = x[3] ^ x[2] ^ (x[0] << 3);
    x[1] = x[1] ^ x[0] ^ x[2];
    x[2] = {x[2][2:0], x[2][31:3]};
    x[0] = {x[0][12:0], x[0][31:13]};
    return x;
  endfunction

endpackage

FILE: rtl/sbc_if.sv
// ----------------------------------------------------------------------------
// sbc_if
// Valid/ready channel interfaces for block words and configuration writes.
// ----------------------------------------------------------------------------
interface sbc_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [63:0] data_in_low;
  logic [63:0] data_in_high;
  modport source (output valid, action, data_in_low, data_in_high, input ready);
  modport sink (input valid, action, data_in_low, data_in_high, output ready);
endinterface

interface sbc_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] data_out_low;
  logic [63:0] data_out_high;
  modport source (output valid, data_out_low, data_out_high, input ready);
  modport sink (input valid, data_out_low, data_out_high, output ready);
endinterface

interface sbc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/sbc_ram.sv
// ----------------------------------------------------------------------------
// sbc_ram
// Generic single-port ram with registered read.
// ----------------------------------------------------------------------------
module sbc_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

FILE: rtl/serpent_block_cipher.sv
// the first word after reset or a key register write waits for key expansion
// one word in flight; in_ready and cfg_ready stay low until the result is taken
// synchronous active-low reset clears control state and keys, loads key length 16
// ----------------------------------------------------------------------------
// serpent_block_cipher
// Iterative 128-bit block cipher with on-chip key schedule.
// ----------------------------------------------------------------------------
module serpent_block_cipher (
  input logic       clk,
  input logic       rst_n,
  sbc_in_if.sink    in_ch,
  sbc_out_if.source out_ch,
  sbc_cfg_if.sink   cfg_ch
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_PRE  = 6'b000010,
    S_SBX  = 6'b000100,
    S_RND  = 6'b001000,
    S_OUT  = 6'b010000,
    S_LOAD = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  logic [63:0] key_r [4];
  logic [5:0]  klen_r;
  logic        kready_r;
  sbc_pkg::word_t win_r [8];
  sbc_pkg::quad_t pre_r;
  logic [7:0]  cnt_r;
  logic [5:0]  grp_r;
  logic        act_r;
  sbc_pkg::quad_t blk_r;
  logic        ovalid_r;

  logic        ram_we;
  logic [5:0]  ram_addr;
  logic [127:0] ram_wdata, ram_rdata;
  sbc_pkg::quad_t rk;

  sbc_ram #(.Width(128), .Depth(sbc_pkg::NumGroups)) u_rk (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );

  assign rk = ram_rdata;
  assign cfg_ch.ready = (state_r == S_IDLE);
  assign in_ch.ready  = (state_r == S_IDLE) && !cfg_ch.valid;
  assign out_ch.valid = ovalid_r;
  assign out_ch.data_out_low  = {blk_r[1], blk_r[0]};
  assign out_ch.data_out_high = {blk_r[3], blk_r[2]};

  logic [5:0] len_c;
  logic [2:0] pidx;
  sbc_pkg::word_t win_init [8];
  sbc_pkg::word_t wnew;
  sbc_pkg::quad_t sbo, kx, rnd;
  logic [5:0] grp_first;
  logic       last_c;

  always_comb begin
    len_c = (klen_r > 6'd32) ? 6'd32 : klen_r;
    pidx  = len_c[4:2];
    // whole key words, then the padding bit for a short key
    for (int i = 0; i < 8; i++) begin
      win_init[i] = '0;
      if (len_c == 6'd32 || 3'(i) < pidx) begin
        win_init[i] = i[0] ? key_r[i >> 1][63:32] : key_r[i >> 1][31:0];
      end else if (3'(i) == pidx) begin
        win_init[i] = 32'd1 << {len_c[1:0], 3'd0};
      end
    end
    wnew  = win_r[0] ^ win_r[3] ^ win_r[5] ^ win_r[7] ^ sbc_pkg::PhiConst
            ^ {24'd0, cnt_r};
    wnew  = {wnew[20:0], wnew[31:21]};
    sbo   = sbc_pkg::sbox_apply(3'(3 - grp_r), 1'b0, pre_r);
    grp_first = (act_r == sbc_pkg::ActEncrypt) ? 6'd0 : 6'd32;
    kx    = blk_r ^ rk;
    if (act_r == sbc_pkg::ActEncrypt) begin
      last_c = (grp_r == 6'd32);
      if (grp_r == 6'd32) begin
        rnd = kx;
      end else if (grp_r == 6'd31) begin
        rnd = sbc_pkg::sbox_apply(3'd7, 1'b0, kx);
      end else begin
        rnd = sbc_pkg::lin_fwd(sbc_pkg::sbox_apply(grp_r[2:0], 1'b0, kx));
      end
    end else begin
      last_c = (grp_r == 6'd0);
      if (grp_r == 6'd0) begin
        rnd = kx;
      end else if (grp_r == 6'd32) begin
        rnd = sbc_pkg::sbox_apply(3'd7, 1'b1, kx);
      end else begin
        rnd = sbc_pkg::sbox_apply(3'(grp_r - 6'd1), 1'b1, sbc_pkg::lin_inv(kx));
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    ram_we    = 1'b0;
    ram_addr  = grp_r;
    ram_wdata = sbo;
    case (state_r)
      S_IDLE: begin
        if (in_ch.valid && in_ch.ready) begin
          state_nxt = kready_r ? S_LOAD : S_PRE;
        end
      end
      S_PRE: begin
        if (cnt_r[1:0] == 2'd3) begin
          state_nxt = S_SBX;
        end
      end
      S_SBX: begin
        ram_we = 1'b1;
        if (grp_r == 6'd32) begin
          state_nxt = S_LOAD;
        end else begin
          state_nxt = S_PRE;
        end
      end
      S_LOAD: begin
        ram_addr  = grp_first;
        state_nxt = S_RND;
      end
      S_RND: begin
        if (last_c) begin
          state_nxt = S_OUT;
        end else if (act_r == sbc_pkg::ActEncrypt) begin
          ram_addr = grp_r + 6'd1;
        end else begin
          ram_addr = grp_r - 6'd1;
        end
      end
      S_OUT: begin
        if (out_ch.valid && out_ch.ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // one key group per round cycle; read of the next group issued alongside
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      kready_r <= 1'b0;
      klen_r   <= 6'd16;
      ovalid_r <= 1'b0;
      cnt_r    <= '0;
      grp_r    <= '0;
      act_r    <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        key_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          sbc_pkg::CfgKeyPart0, sbc_pkg::CfgKeyPart1,
          sbc_pkg::CfgKeyPart2, sbc_pkg::CfgKeyPart3: begin
            key_r[cfg_ch.index[1:0]] <= cfg_ch.data;
            kready_r <= 1'b0;
          end
          sbc_pkg::CfgKeyLength: begin
            klen_r   <= cfg_ch.data[5:0];
            kready_r <= 1'b0;
          end
          default: ;
        endcase
      end
      case (state_r)
        S_IDLE: begin
          if (in_ch.valid && in_ch.ready) begin
            act_r  <= in_ch.action;
            blk_r  <= {in_ch.data_in_high, in_ch.data_in_low};
            cnt_r  <= '0;
            grp_r  <= '0;
            for (int i = 0; i < 8; i++) begin
              win_r[i] <= win_init[i];
            end
          end
        end
        S_PRE: begin
          for (int i = 0; i < 7; i++) begin
            win_r[i] <= win_r[i+1];
          end
          win_r[7] <= wnew;
          pre_r[cnt_r[1:0]] <= wnew;
          cnt_r <= cnt_r + 8'd1;
        end
        S_SBX: begin
          grp_r <= grp_r + 6'd1;
          if (grp_r == 6'd32) begin
            kready_r <= 1'b1;
          end
        end
        S_LOAD: begin
          grp_r <= grp_first;
        end
        S_RND: begin
          blk_r <= rnd;
          if (last_c) begin
            ovalid_r <= 1'b1;
          end else if (act_r == sbc_pkg::ActEncrypt) begin
            grp_r <= grp_r + 6'd1;
          end else begin
            grp_r <= grp_r - 6'd1;
          end
        end
        S_OUT: begin
          if (out_ch.valid && out_ch.ready) begin
            ovalid_r <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

FILE: rtl/sbc_checker.sv
// ----------------------------------------------------------------------------
// sbc_checker
// Port-level checks on the cipher handshakes.
// ----------------------------------------------------------------------------
module sbc_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic cfg_ready
);
  a_no_in_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input taken with result pending");
  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready) else $error("ready after accept");
  a_no_cfg_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !cfg_ready) else $error("cfg while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid) else $error("result dropped");
endmodule

bind serpent_block_cipher sbc_checker u_chk (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .cfg_ready(cfg_ch.ready)
);
